// ----- rtl/rlks_pkg.sv -----
// Package: codes, types and defaults shared by the keepalive scheduler files.
package rlks_pkg;

   // Link machine state codes
   localparam logic [2:0] ST_RESET       = 3'd0;
   localparam logic [2:0] ST_UNCONN      = 3'd1;
   localparam logic [2:0] ST_UNCONN_WAIT = 3'd2;
   localparam logic [2:0] ST_CONN        = 3'd3;
   localparam logic [2:0] ST_CONN_WAIT   = 3'd4;

   // Packet kind codes
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_STIM = 3'd1;
   localparam logic [2:0] KIND_PING = 3'd2;
   localparam logic [2:0] KIND_RESP = 3'd3;
   localparam logic [2:0] KIND_ACT  = 3'd4;
   localparam logic [2:0] KIND_SENS = 3'd5;

   // Defaults
   localparam int          TIMER_WIDTH_DEF = 16;
   localparam int          PERIOD_WIDTH    = 16;
   localparam logic [15:0] PERIOD_RESET    = 16'd1000;

   // Event bits of one tick
   typedef struct packed {
      logic radio_idle;
      logic tx_finished;
      logic ping_reply_seen;
      logic command_seen;
      logic stimulus_request;
      logic sensor_data_request;
      logic actuator_command_request;
   } event_type;

   // Machine state and pending flags
   typedef struct packed {
      logic [2:0] machine_state;
      logic       stimulus_pending;
      logic       response_pending;
      logic       actuator_pending;
      logic       sensor_pending;
      logic       timeout_flag;
      logic       reply_flag;
      logic       done_flag;
      logic       timer_running;
   } link_type;

   // One result
   typedef struct packed {
      logic [2:0] send_kind;
      logic [2:0] link_state;
      logic       timer_restarted;
   } result_type;

endpackage

// ----- rtl/rlks_if.sv -----
// Interfaces: tick request, result and period write channels.
interface rlks_req_if;
   logic valid;
   logic ready;
   logic radio_idle;
   logic tx_finished;
   logic ping_reply_seen;
   logic command_seen;
   logic stimulus_request;
   logic sensor_data_request;
   logic actuator_command_request;

   modport source (
      output valid, radio_idle, tx_finished, ping_reply_seen, command_seen,
             stimulus_request, sensor_data_request, actuator_command_request,
      input  ready
   );
   modport sink (
      input  valid, radio_idle, tx_finished, ping_reply_seen, command_seen,
             stimulus_request, sensor_data_request, actuator_command_request,
      output ready
   );
endinterface

interface rlks_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] send_kind;
   logic [2:0] link_state;
   logic       timer_restarted;

   modport source (
      output valid, send_kind, link_state, timer_restarted,
      input  ready
   );
   modport sink (
      input  valid, send_kind, link_state, timer_restarted,
      output ready
   );
endinterface

interface rlks_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface

// ----- rtl/rlks_core.sv -----
// Next-state logic: event latching, ping timer and link machine for one tick.
module rlks_core #(
   parameter int TIMER_WIDTH = rlks_pkg::TIMER_WIDTH_DEF
) (
   input  rlks_pkg::event_type        ev,
   input  rlks_pkg::link_type         cur,
   input  logic [TIMER_WIDTH-1:0]     count_cur,
   input  logic [15:0]                period,
   output rlks_pkg::link_type         nxt,
   output logic [TIMER_WIDTH-1:0]     count_nxt,
   output rlks_pkg::result_type       res
);
   import rlks_pkg::*;

   localparam int EW = (TIMER_WIDTH > PERIOD_WIDTH) ? TIMER_WIDTH : PERIOD_WIDTH;
   localparam logic [EW-1:0] CNT_MAX = EW'({TIMER_WIDTH{1'b1}});

   logic [EW-1:0]          period_ext;
   logic [TIMER_WIDTH-1:0] period_eff;
   logic [TIMER_WIDTH:0]   count_inc;

   // Clamp the period to what the counter can hold
   always_comb begin
      period_ext = EW'(period);
      if (period_ext > CNT_MAX) begin
         period_eff = TIMER_WIDTH'(CNT_MAX);
      end else begin
         period_eff = TIMER_WIDTH'(period_ext);
      end
      count_inc = {1'b0, count_cur} + (TIMER_WIDTH+1)'(1);
   end

   always_comb begin
      nxt       = cur;
      count_nxt = count_cur;
      res       = '0;

      // Latch events into pending flags
      if (ev.tx_finished)              nxt.done_flag        = 1'b1;
      if (ev.ping_reply_seen)          nxt.reply_flag       = 1'b1;
      if (ev.command_seen)             nxt.response_pending = 1'b1;
      if (ev.stimulus_request)         nxt.stimulus_pending = 1'b1;
      if (ev.sensor_data_request)      nxt.sensor_pending   = 1'b1;
      if (ev.actuator_command_request) nxt.actuator_pending = 1'b1;

      // Advance the single-shot timer
      if (cur.timer_running) begin
         if (count_inc >= {1'b0, period_eff}) begin
            nxt.timeout_flag  = 1'b1;
            nxt.timer_running = 1'b0;
            count_nxt         = '0;
         end else begin
            count_nxt = count_inc[TIMER_WIDTH-1:0];
         end
      end

      // Run the link machine
      case (cur.machine_state)
         ST_UNCONN: begin
            if (nxt.stimulus_pending && ev.radio_idle) begin
               nxt.done_flag        = 1'b0;
               nxt.stimulus_pending = 1'b0;
               res.send_kind        = KIND_STIM;
               nxt.machine_state    = ST_UNCONN_WAIT;
            end else if (nxt.timeout_flag && ev.radio_idle) begin
               nxt.timeout_flag    = 1'b0;
               nxt.timer_running   = 1'b1;
               count_nxt           = '0;
               res.timer_restarted = 1'b1;
               nxt.done_flag       = 1'b0;
               nxt.reply_flag      = 1'b0;
               res.send_kind       = KIND_PING;
               nxt.machine_state   = ST_UNCONN_WAIT;
            end else if (nxt.reply_flag) begin
               nxt.timeout_flag    = 1'b0;
               nxt.timer_running   = 1'b1;
               count_nxt           = '0;
               res.timer_restarted = 1'b1;
               nxt.sensor_pending  = 1'b0;
               nxt.machine_state   = ST_CONN;
            end
         end
         ST_UNCONN_WAIT: begin
            if (nxt.done_flag) begin
               nxt.done_flag     = 1'b0;
               nxt.machine_state = ST_UNCONN;
            end
            if (nxt.timeout_flag) nxt.machine_state = ST_RESET;
         end
         ST_CONN: begin
            if (nxt.stimulus_pending) begin
               nxt.done_flag        = 1'b0;
               nxt.stimulus_pending = 1'b0;
               res.send_kind        = KIND_STIM;
               nxt.machine_state    = ST_CONN_WAIT;
            end else if (nxt.response_pending) begin
               nxt.timer_running    = 1'b1;
               count_nxt            = '0;
               res.timer_restarted  = 1'b1;
               nxt.done_flag        = 1'b0;
               nxt.response_pending = 1'b0;
               res.send_kind        = KIND_RESP;
               nxt.machine_state    = ST_CONN_WAIT;
            end else if (nxt.actuator_pending) begin
               nxt.done_flag        = 1'b0;
               nxt.actuator_pending = 1'b0;
               res.send_kind        = KIND_ACT;
               nxt.machine_state    = ST_CONN_WAIT;
            end else if (nxt.sensor_pending) begin
               nxt.done_flag      = 1'b0;
               nxt.sensor_pending = 1'b0;
               res.send_kind      = KIND_SENS;
               nxt.machine_state  = ST_CONN_WAIT;
            end else if (nxt.timeout_flag) begin
               nxt.timeout_flag     = 1'b0;
               nxt.timer_running    = 1'b1;
               count_nxt            = '0;
               res.timer_restarted  = 1'b1;
               nxt.response_pending = 1'b0;
               res.send_kind        = KIND_PING;
               nxt.machine_state    = ST_UNCONN;
            end else if (nxt.reply_flag) begin
               nxt.reply_flag      = 1'b0;
               nxt.timeout_flag    = 1'b0;
               nxt.timer_running   = 1'b1;
               count_nxt           = '0;
               res.timer_restarted = 1'b1;
            end
         end
         ST_CONN_WAIT: begin
            if (nxt.done_flag)    nxt.machine_state = ST_CONN;
            if (nxt.timeout_flag) nxt.machine_state = ST_RESET;
         end
         default: begin
            // Reset state, and any code that cannot arise
            nxt.timeout_flag    = 1'b0;
            nxt.timer_running   = 1'b1;
            count_nxt           = '0;
            res.timer_restarted = 1'b1;
            nxt.machine_state   = ST_UNCONN;
         end
      endcase

      res.link_state = nxt.machine_state;
   end

endmodule

// ----- rtl/radio_link_keepalive_scheduler_unit.sv -----
// Top level: keepalive scheduler with tick input, result output and period register.
//
// Each transaction on req_if is one tick carrying event bits (radio idle,
// transmission finished, ping reply, command seen, and send requests).
// Each accepted tick yields exactly one transaction on rsp_if: the packet
// kind to send (or none), the link state after the tick, and whether the
// ping timer was restarted.
// The result is registered and is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle while rsp_if is not stalled; the state update and the result are
// computed by one combinational pass between the state/result registers.
// rsp_if has a single output register; req_if.ready is high whenever that
// register is empty or is being taken, so a stalled receiver holds the
// result and stalls the input after one tick.
// csr_if writes ping_period (16 bits) and is always ready; write it only
// while no tick is in flight.
// Reset (synchronous): link machine in the reset state, all flags clear,
// timer stopped, ping_period 1000, no result pending.
module radio_link_keepalive_scheduler_unit #(
   parameter int TIMER_WIDTH = rlks_pkg::TIMER_WIDTH_DEF
) (
   input logic          clock,
   input logic          reset,
   rlks_req_if.sink     req_if,
   rlks_rsp_if.source   rsp_if,
   rlks_csr_if.sink     csr_if
);
   import rlks_pkg::*;

   link_type               link_ff, link_in;
   logic [TIMER_WIDTH-1:0] count_ff, count_in;
   logic [15:0]            period_ff;
   logic                   rsp_valid_ff;
   result_type             res_ff, res_in;
   event_type              ev;
   logic                   accept;

   // Gather the tick's event bits
   assign ev.radio_idle               = req_if.radio_idle;
   assign ev.tx_finished              = req_if.tx_finished;
   assign ev.ping_reply_seen          = req_if.ping_reply_seen;
   assign ev.command_seen             = req_if.command_seen;
   assign ev.stimulus_request         = req_if.stimulus_request;
   assign ev.sensor_data_request      = req_if.sensor_data_request;
   assign ev.actuator_command_request = req_if.actuator_command_request;

   // Take a tick whenever the result register is free or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   rlks_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .ev        (ev),
      .cur       (link_ff),
      .count_cur (count_ff),
      .period    (period_ff),
      .nxt       (link_in),
      .count_nxt (count_in),
      .res       (res_in)
   );

   // Advance state and the result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff      <= '0;
         count_ff     <= '0;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            period_ff <= csr_if.data;
         end
         if (accept) begin
            link_ff  <= link_in;
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.send_kind       = res_ff.send_kind;
   assign rsp_if.link_state      = res_ff.link_state;
   assign rsp_if.timer_restarted = res_ff.timer_restarted;

endmodule

// ----- tb/sv/tb_radio_link_keepalive_scheduler_unit.sv -----
// Testbench: random and directed ticks into the keepalive scheduler, results checked by a predictor.
module tb_radio_link_keepalive_scheduler_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rlks_pkg::*;

   // Event bits in the field order of event_type, radio_idle first
   localparam logic [6:0] EV_NONE  = 7'b0000000;
   localparam logic [6:0] EV_IDLE  = 7'b1000000;
   localparam logic [6:0] EV_FIN   = 7'b0100000;
   localparam logic [6:0] EV_REPLY = 7'b0010000;
   localparam logic [6:0] EV_CMD   = 7'b0001000;
   localparam logic [6:0] EV_STIM  = 7'b0000100;
   localparam logic [6:0] EV_SENS  = 7'b0000010;
   localparam logic [6:0] EV_ACT   = 7'b0000001;

   localparam int PHASES       = 12;
   localparam int PHASE_TICKS  = 170;
   localparam int STALL_CYCLES = 300;
   localparam int LIMIT_CYCLES = 200000;

   logic clock;
   logic reset;

   rlks_req_if req_if ();
   rlks_rsp_if rsp_if ();
   rlks_csr_if csr_if ();

   radio_link_keepalive_scheduler_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   event_type   pending_ticks [$];
   result_type  due_results [$];
   int unsigned tick_pct [7];
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stalls_asked;
   int unsigned stalls_served;
   int unsigned stall_left;
   int unsigned mismatch_count;
   int unsigned cycle_count;
   logic        tick_taken;

   // Predicted scheduler state
   logic [2:0]  link_st    = ST_RESET;
   logic        stim_pend  = 1'b0;
   logic        resp_pend  = 1'b0;
   logic        act_pend   = 1'b0;
   logic        sens_pend  = 1'b0;
   logic        tmo_seen   = 1'b0;
   logic        reply_seen = 1'b0;
   logic        tx_done    = 1'b0;
   logic [15:0] tmr_count  = 16'd0;
   logic        tmr_on     = 1'b0;
   logic [15:0] period_q   = PERIOD_RESET;

   function automatic void restart_timer();
      tmr_count = 16'd0;
      tmr_on    = 1'b1;
   endfunction

   // Latch events, advance the ping timer, then run the link machine
   function automatic result_type advance_link(event_type ev);
      result_type  r;
      logic [16:0] cnt_next;
      logic [2:0]  st_next;
      r.send_kind       = KIND_NONE;
      r.timer_restarted = 1'b0;
      st_next           = link_st;

      if (ev.tx_finished) tx_done = 1'b1;
      if (ev.ping_reply_seen) reply_seen = 1'b1;
      if (ev.command_seen) resp_pend = 1'b1;
      if (ev.stimulus_request) stim_pend = 1'b1;
      if (ev.sensor_data_request) sens_pend = 1'b1;
      if (ev.actuator_command_request) act_pend = 1'b1;

      // A zero period expires like a period of one
      if (tmr_on) begin
         cnt_next = {1'b0, tmr_count} + 17'd1;
         if (cnt_next >= {1'b0, period_q}) begin
            tmo_seen  = 1'b1;
            tmr_on    = 1'b0;
            tmr_count = 16'd0;
         end else begin
            tmr_count = cnt_next[15:0];
         end
      end

      case (link_st)
         ST_UNCONN: begin
            if (stim_pend && ev.radio_idle) begin
               tx_done     = 1'b0;
               stim_pend   = 1'b0;
               r.send_kind = KIND_STIM;
               st_next     = ST_UNCONN_WAIT;
            end else if (tmo_seen && ev.radio_idle) begin
               tmo_seen = 1'b0;
               restart_timer();
               r.timer_restarted = 1'b1;
               tx_done     = 1'b0;
               reply_seen  = 1'b0;
               r.send_kind = KIND_PING;
               st_next     = ST_UNCONN_WAIT;
            end else if (reply_seen) begin
               tmo_seen = 1'b0;
               restart_timer();
               r.timer_restarted = 1'b1;
               sens_pend = 1'b0;
               st_next   = ST_CONN;
            end
         end
         ST_UNCONN_WAIT: begin
            if (tx_done) begin
               tx_done = 1'b0;
               st_next = ST_UNCONN;
            end
            if (tmo_seen) st_next = ST_RESET;
         end
         ST_CONN: begin
            // Connected sends ignore radio_idle
            if (stim_pend) begin
               tx_done     = 1'b0;
               stim_pend   = 1'b0;
               r.send_kind = KIND_STIM;
               st_next     = ST_CONN_WAIT;
            end else if (resp_pend) begin
               restart_timer();
               r.timer_restarted = 1'b1;
               tx_done     = 1'b0;
               resp_pend   = 1'b0;
               r.send_kind = KIND_RESP;
               st_next     = ST_CONN_WAIT;
            end else if (act_pend) begin
               tx_done     = 1'b0;
               act_pend    = 1'b0;
               r.send_kind = KIND_ACT;
               st_next     = ST_CONN_WAIT;
            end else if (sens_pend) begin
               tx_done     = 1'b0;
               sens_pend   = 1'b0;
               r.send_kind = KIND_SENS;
               st_next     = ST_CONN_WAIT;
            end else if (tmo_seen) begin
               // Ping from connected drops straight to unconnected
               tmo_seen = 1'b0;
               restart_timer();
               r.timer_restarted = 1'b1;
               resp_pend   = 1'b0;
               r.send_kind = KIND_PING;
               st_next     = ST_UNCONN;
            end else if (reply_seen) begin
               reply_seen = 1'b0;
               tmo_seen   = 1'b0;
               restart_timer();
               r.timer_restarted = 1'b1;
            end
         end
         ST_CONN_WAIT: begin
            // Keep tx_done set here
            if (tx_done) st_next = ST_CONN;
            if (tmo_seen) st_next = ST_RESET;
         end
         default: begin
            tmo_seen = 1'b0;
            restart_timer();
            r.timer_restarted = 1'b1;
            st_next = ST_UNCONN;
         end
      endcase
      link_st      = st_next;
      r.link_state = link_st;
      return r;
   endfunction

   // Draw one tick, each event bit set with its own percentage
   function automatic event_type rand_tick();
      logic [6:0] bits;
      for (int i = 0; i < 7; i++) bits[6 - i] = ($urandom_range(99) < tick_pct[i]);
      return event_type'(bits);
   endfunction

   function automatic void push_tick(logic [6:0] bits);
      pending_ticks.push_back(event_type'(bits));
   endfunction

   // Hold until no tick is queued or in flight, then let the pipeline settle
   task automatic drain();
      while (pending_ticks.size() != 0 || due_results.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.data  = value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      period_q = value;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d results due", $time, due_results.size());
         $display("[radio_link_keepalive_scheduler_unit] ERROR");
         $finish;
      end
   end

   // Drive ticks from the pending queue; keep an offered tick until it is taken
   always @(negedge clock) begin : tick_driver
      event_type head;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (tick_taken) void'(pending_ticks.pop_front());
         if (req_if.valid && !tick_taken) begin
            // hold the current offer
         end else if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            head = pending_ticks[0];
            req_if.valid                    <= 1'b1;
            req_if.radio_idle               <= head.radio_idle;
            req_if.tx_finished              <= head.tx_finished;
            req_if.ping_reply_seen          <= head.ping_reply_seen;
            req_if.command_seen             <= head.command_seen;
            req_if.stimulus_request         <= head.stimulus_request;
            req_if.sensor_data_request      <= head.sensor_data_request;
            req_if.actuator_command_request <= head.actuator_command_request;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Throttle the result side; serve each long hold-off request in turn
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (stalls_served != stalls_asked) begin
         rsp_if.ready  <= 1'b0;
         stalls_served <= stalls_served + 1;
         stall_left    <= STALL_CYCLES;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each result transaction, then predict from each accepted tick
   always @(posedge clock) begin : link_monitor
      result_type want;
      result_type seen;
      event_type  ev;
      if (reset) begin
         tick_taken <= 1'b0;
      end else begin
         tick_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            seen.send_kind       = rsp_if.send_kind;
            seen.link_state      = rsp_if.link_state;
            seen.timer_restarted = rsp_if.timer_restarted;
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result kind %0d state %0d restart %0b", $time,
                        seen.send_kind, seen.link_state, seen.timer_restarted);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = due_results.pop_front();
               if (seen.send_kind !== want.send_kind || seen.link_state !== want.link_state ||
                   seen.timer_restarted !== want.timer_restarted) begin
                  $display("%0t: expected kind %0d state %0d restart %0b, got %0d %0d %0b",
                           $time, want.send_kind, want.link_state, want.timer_restarted,
                           seen.send_kind, seen.link_state, seen.timer_restarted);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            ev.radio_idle               = req_if.radio_idle;
            ev.tx_finished              = req_if.tx_finished;
            ev.ping_reply_seen          = req_if.ping_reply_seen;
            ev.command_seen             = req_if.command_seen;
            ev.stimulus_request         = req_if.stimulus_request;
            ev.sensor_data_request      = req_if.sensor_data_request;
            ev.actuator_command_request = req_if.actuator_command_request;
            due_results.push_back(advance_link(ev));
         end
      end
   end

   initial begin : stimulus
      logic [15:0] per;
      reset                           = 1'b1;
      req_if.valid                    = 1'b0;
      req_if.radio_idle               = 1'b0;
      req_if.tx_finished              = 1'b0;
      req_if.ping_reply_seen          = 1'b0;
      req_if.command_seen             = 1'b0;
      req_if.stimulus_request         = 1'b0;
      req_if.sensor_data_request      = 1'b0;
      req_if.actuator_command_request = 1'b0;
      rsp_if.ready                    = 1'b0;
      csr_if.valid                    = 1'b0;
      csr_if.data                     = 16'd0;
      send_idle_pct                   = 18;
      recv_idle_pct                   = 50;
      stalls_asked                    = 0;
      stalls_served                   = 0;
      stall_left                      = 0;
      mismatch_count                  = 0;
      cycle_count                     = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk each non-ping send at the reset period: stimulus gated by radio_idle while
      // unconnected, reply drops sensor data, connected priority order
      push_tick(EV_NONE);
      push_tick(EV_STIM);
      push_tick(EV_IDLE);
      push_tick(EV_FIN);
      push_tick(EV_REPLY | EV_SENS);
      push_tick(EV_CMD | EV_STIM | EV_SENS | EV_ACT);
      push_tick(EV_FIN);
      push_tick(EV_NONE);
      push_tick(EV_FIN);
      push_tick(EV_NONE);
      push_tick(EV_FIN);
      push_tick(EV_NONE);
      push_tick(EV_FIN);
      push_tick(EV_REPLY);
      drain();

      // Short period: ping from connected, timeout blocked by a busy radio,
      // ping from unconnected, timeout in the wait state back to reset
      write_period(16'd3);
      repeat (6) push_tick(EV_NONE);
      push_tick(EV_IDLE);
      repeat (4) push_tick(EV_NONE);
      drain();

      // Random phases: extremes of the period first, idling pattern per third
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: per = 16'd0;
            1: per = 16'd1;
            2: per = 16'hFFFF;
            3: per = 16'd2;
            default: per = 16'($urandom_range(40, 2));
         endcase
         write_period(per);
         if (ph < PHASES / 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 50;
         end else if (ph < 2 * PHASES / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Mostly link-friendly event mixes, every fourth phase plain noise
         if (ph % 4 == 3) begin
            for (int i = 0; i < 7; i++) tick_pct[i] = 50;
         end else begin
            tick_pct[0] = $urandom_range(95, 50);
            tick_pct[1] = $urandom_range(60, 10);
            tick_pct[2] = $urandom_range(40, 5);
            for (int i = 3; i < 7; i++) tick_pct[i] = $urandom_range(30, 0);
         end
         repeat (PHASE_TICKS) pending_ticks.push_back(rand_tick());
         // Hold the result side long enough to back up the input
         if (ph == 0 || ph == 5) stalls_asked = stalls_asked + 1;
         drain();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[radio_link_keepalive_scheduler_unit] OK");
      end else begin
         $display("[radio_link_keepalive_scheduler_unit] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/rlks_pkg.sv
rtl/rlks_if.sv
rtl/rlks_core.sv
rtl/radio_link_keepalive_scheduler_unit.sv
tb/sv/tb_radio_link_keepalive_scheduler_unit.sv
